// ----- sv/binomial_coefficient_unit_macros.svh -----
// Assertion helpers shared by the binomial coefficient unit.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef BINOMIAL_COEFFICIENT_UNIT_MACROS_SVH
`define BINOMIAL_COEFFICIENT_UNIT_MACROS_SVH

// Same-cycle implication.
`define BCU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bcu assertion failed");

// Next-cycle implication.
`define BCU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bcu assertion failed");

`endif

// ----- sv/bcu_pkg.sv -----
// ----------------------------------------------------------------------------
// bcu_pkg
// Types and constants of the binomial coefficient unit.
// ----------------------------------------------------------------------------
package bcu_pkg;

	localparam int ACC_W  = 64;
	localparam int HALF_W = 32;
	localparam int DIV_CNT_W = $clog2(ACC_W);

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_K_GT_N   = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL_LO,
		S_MUL_HI,
		S_DIV_START,
		S_DIV_WAIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- sv/bcu_in_if.sv -----
// ----------------------------------------------------------------------------
// bcu_in_if
// Request channel: one item carries n and k.
// ----------------------------------------------------------------------------
interface bcu_in_if #(
	parameter int ARG_WIDTH = 8
);
	logic                 valid;
	logic                 ready;
	logic [ARG_WIDTH-1:0] n;
	logic [ARG_WIDTH-1:0] k;

	modport source (output valid, output n, output k, input ready);
	modport sink   (input valid, input n, input k, output ready);
endinterface

// ----- sv/bcu_out_if.sv -----
// ----------------------------------------------------------------------------
// bcu_out_if
// Response channel: one item carries the coefficient and a status code.
// ----------------------------------------------------------------------------
interface bcu_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] coefficient;
	logic [1:0]  status;

	modport source (output valid, output coefficient, output status, input ready);
	modport sink   (input valid, input coefficient, input status, output ready);
endinterface

// ----- sv/bcu_div.sv -----
// ----------------------------------------------------------------------------
// bcu_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bcu_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [bcu_pkg::ACC_W-1:0] dividend,
	input  logic [bcu_pkg::ACC_W-1:0] divisor,
	output logic [bcu_pkg::ACC_W-1:0] quotient,
	output bcu_pkg::div_stat_t        stat
);
	import bcu_pkg::*;

	logic [ACC_W-1:0]     rem_q;
	logic [ACC_W-1:0]     quo_q;
	logic [ACC_W-1:0]     den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [ACC_W:0]       rem_sh;
	logic [ACC_W:0]       diff;
	logic                 fits;

	// shift in next dividend bit, trial subtract
	assign rem_sh = {rem_q, quo_q[ACC_W-1]};
	assign diff   = rem_sh - {1'b0, den_q};
	assign fits   = !diff[ACC_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(ACC_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[ACC_W-1:0] : rem_sh[ACC_W-1:0];
			quo_q <= {quo_q[ACC_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign stat     = '{busy: busy_q, done: done_q};

endmodule

// ----- sv/binomial_coefficient_unit.sv -----
// ----------------------------------------------------------------------------
// binomial_coefficient_unit
// C(n,k) by the multiplicative formula with 64-bit overflow detection.
// ----------------------------------------------------------------------------
// Usage:
//   req  (bcu_in_if.sink):    one item per question, fields n and k.
//   rsp  (bcu_out_if.source): one item per request, coefficient and status.
//   Status codes: ok, k exceeds n, intermediate product overflow; the
//   coefficient reads zero whenever status is not ok.
// Timing:
//   One item is in work at a time; req.ready is high only while idle.
//   k > n answers without multiplying or dividing. Otherwise, with m = min(k, n-k),
//   each of the m steps uses the one shared 32 x ARG_WIDTH multiplier
//   (two halves each for numerator and denominator), then a restoring
//   division runs. Any successful item has m <= 20 (21! exceeds 64
//   bits); overflow ends the item early.
// Reset: arst_n clears the sequencer and drops rsp.valid; nothing pending.
// Stall: the finished result sits in the output register; the next request
//   is accepted meanwhile, and its result waits until rsp.ready drains it.
// ----------------------------------------------------------------------------
`include "binomial_coefficient_unit_macros.svh"

module binomial_coefficient_unit #(
	parameter int ARG_WIDTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	bcu_in_if.sink     req,
	bcu_out_if.source  rsp
);
	import bcu_pkg::*;

	localparam int PROD_W = HALF_W + ARG_WIDTH;

	state_t state_q, state_d;

	// operands and loop control
	logic [ARG_WIDTH-1:0] n_q;
	logic [ARG_WIDTH-1:0] m_q;
	logic [ARG_WIDTH-1:0] i_q;
	logic                 sel_q;     // 0: numerator step, 1: denominator step
	logic [ACC_W-1:0]     numer_q;
	logic [ACC_W-1:0]     denom_q;
	logic [PROD_W-1:0]    lo_q;

	// pending result and output register
	status_t              res_status_q;
	logic [ACC_W-1:0]     res_coef_q;
	logic                 rsp_valid_q;
	logic [ACC_W-1:0]     rsp_coef_q;
	status_t              rsp_status_q;

	// request decode
	logic                 accept;
	logic                 k_gt_n;
	logic [ARG_WIDTH-1:0] n_minus_k;
	logic [ARG_WIDTH-1:0] m_new;

	// shared multiplier
	logic [ACC_W-1:0]     acc;
	logic [ARG_WIDTH-1:0] fac;
	logic [HALF_W-1:0]    mul_a;
	logic [PROD_W-1:0]    prod;
	logic [PROD_W-1:0]    mac;
	logic                 ovf;
	logic                 last_step;

	// sequencer outputs
	logic                 req_ready;
	logic                 div_start;
	logic                 out_free;
	logic                 load_out;

	// divider
	logic [ACC_W-1:0]     quotient;
	div_stat_t            div_stat;

	assign accept    = req.valid && req_ready;
	assign k_gt_n    = req.k > req.n;
	assign n_minus_k = req.n - req.k;
	assign m_new     = (req.k < n_minus_k) ? req.k : n_minus_k;

	// Factor: n+1-i for the numerator, i for the denominator
	assign acc   = sel_q ? denom_q : numer_q;
	assign fac   = sel_q ? i_q : ARG_WIDTH'(n_q - i_q + 1'b1);
	assign mul_a = (state_q == S_MUL_HI) ? acc[ACC_W-1:HALF_W] : acc[HALF_W-1:0];
	assign prod  = PROD_W'(mul_a) * PROD_W'(fac);

	// High half product plus carry bits of the low half product
	assign mac = prod + PROD_W'(lo_q[PROD_W-1:HALF_W]);
	assign ovf = |mac[PROD_W-1:HALF_W];
	assign last_step = sel_q && (i_q == m_q);

	assign out_free = !rsp_valid_q || rsp.ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					if (k_gt_n) begin
						state_d = S_DONE;
					end else if (m_new == '0) begin
						state_d = S_DIV_START;
					end else begin
						state_d = S_MUL_LO;
					end
				end
			end
			S_MUL_LO: begin
				state_d = S_MUL_HI;
			end
			S_MUL_HI: begin
				if (ovf) begin
					state_d = S_DONE;
				end else if (last_step) begin
					state_d = S_DIV_START;
				end else begin
					state_d = S_MUL_LO;
				end
			end
			S_DIV_START: begin
				state_d = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (div_stat.done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		req_ready = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
			end
			S_DIV_START: begin
				div_start = 1'b1;
			end
			S_DONE: begin
				load_out = out_free;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sel_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				sel_q <= 1'b0;
			end else if (state_q == S_MUL_HI) begin
				sel_q <= !sel_q;
			end
			// load a finished result, else drop it once taken
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q          <= req.n;
			m_q          <= m_new;
			i_q          <= ARG_WIDTH'(1);
			numer_q      <= ACC_W'(1);
			denom_q      <= ACC_W'(1);
			res_status_q <= k_gt_n ? ST_K_GT_N : ST_OK;
			res_coef_q   <= '0;
		end
		if (state_q == S_MUL_LO) begin
			lo_q <= prod;
		end
		if (state_q == S_MUL_HI) begin
			if (ovf) begin
				res_status_q <= ST_OVERFLOW;
				res_coef_q   <= '0;
			end else begin
				if (sel_q) begin
					denom_q <= {mac[HALF_W-1:0], lo_q[HALF_W-1:0]};
					i_q     <= i_q + 1'b1;
				end else begin
					numer_q <= {mac[HALF_W-1:0], lo_q[HALF_W-1:0]};
				end
			end
		end
		if (state_q == S_DIV_WAIT && div_stat.done) begin
			res_coef_q <= quotient;
		end
		if (load_out) begin
			rsp_coef_q   <= res_coef_q;
			rsp_status_q <= res_status_q;
		end
	end

	bcu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (numer_q),
		.divisor  (denom_q),
		.quotient (quotient),
		.stat     (div_stat)
	);

	assign req.ready       = req_ready;
	assign rsp.valid       = rsp_valid_q;
	assign rsp.coefficient = rsp_coef_q;
	assign rsp.status      = rsp_status_q;

	// A failed item never carries a nonzero coefficient
	`BCU_ASSERT_IMP(a_zero_on_error, rsp.valid && rsp.status != ST_OK, rsp.coefficient == '0)
	// Loop counter stays within 1..m while multiplying
	`BCU_ASSERT_IMP(a_step_range, state_q == S_MUL_LO || state_q == S_MUL_HI,
		i_q != '0 && i_q <= m_q)
	// Divider is only started when free, and only reports to the waiting state
	`BCU_ASSERT_IMP(a_div_free, div_start, !div_stat.busy)
	`BCU_ASSERT_IMP(a_div_done, div_stat.done, state_q == S_DIV_WAIT)
	// A started division keeps the divider busy on the next cycle
	`BCU_ASSERT_NXT(a_div_busy, div_start, div_stat.busy && state_q == S_DIV_WAIT)

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the binomial coefficient unit. Sends (n, k)
// requests and computes C(n,k) for each one with a 64-bit overflow check.
// Each response is checked, field by field, against the oldest open answer.
// The run covers directed corner cases, a long receiver hold-off, a pause
// until the unit drains, and random requests under four idle/stall mixes.
// ----------------------------------------------------------------------------
module tb;
	import bcu_pkg::*;

	localparam int ARG_W = 8;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 200;

	typedef struct {
		logic [63:0] coefficient;
		status_t     status;
	} coeff_answer_t;

	logic clk;
	logic arst_n;

	bcu_in_if #(.ARG_WIDTH(ARG_W)) req_if ();
	bcu_out_if rsp_if ();

	binomial_coefficient_unit #(.ARG_WIDTH(ARG_W)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// Answers still owed by the unit, oldest first.
	coeff_answer_t open_answers[$];
	int            error_count = 0;
	int            cycle_count = 0;
	int            tx_idle_pct = 0;
	int            rx_stall_pct = 0;
	logic          rx_hold = 1'b0;

	// 12 ns period: 6 ns high, 6 ns low.
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Run the multiplicative formula at 128 bits and flag any step whose
	// numerator or denominator leaves the low 64 bits. The numerator is
	// checked first within a step, as the unit does.
	function automatic coeff_answer_t predict_coefficient(input logic [ARG_W-1:0] n,
			input logic [ARG_W-1:0] k);
		coeff_answer_t     answer;
		logic [127:0]      numer;
		logic [127:0]      denom;
		logic [ARG_W-1:0]  m;
		answer.coefficient = '0;
		answer.status = ST_OK;
		if (k > n) begin
			answer.status = ST_K_GT_N;
			return answer;
		end
		m = (k < n - k) ? k : n - k;
		numer = 128'd1;
		denom = 128'd1;
		for (int i = 1; i <= m; i++) begin
			numer = numer * 128'(n + 1 - i);
			if (numer[127:64] != '0) begin
				answer.status = ST_OVERFLOW;
				return answer;
			end
			denom = denom * 128'(i);
			if (denom[127:64] != '0) begin
				answer.status = ST_OVERFLOW;
				return answer;
			end
		end
		answer.coefficient = numer[63:0] / denom[63:0];
		return answer;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
		error_count++;
	endtask

	// Offer one request; idle first at the sender's current rate. Valid stays
	// high across back-to-back items, so it gets one assignment per edge.
	task automatic send_request(input logic [ARG_W-1:0] n, input logic [ARG_W-1:0] k);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_if.valid <= 1'b0;
			req_if.n     <= ARG_W'($urandom);
			req_if.k     <= ARG_W'($urandom);
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.n     <= n;
		req_if.k     <= k;
		do
			@(posedge clk);
		while (!req_if.ready);
		open_answers = {open_answers, predict_coefficient(n, k)};
	endtask

	task automatic idle_sender();
		req_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Hold the sender until every owed answer has come back.
	task automatic wait_drained();
		idle_sender();
		while (open_answers.size() != 0)
			@(posedge clk);
	endtask

	// Drop ready for a fixed stretch; counted here, apart from the sender.
	task automatic hold_receiver(input int cycles);
		rx_hold <= 1'b1;
		repeat (cycles) @(posedge clk);
		rx_hold <= 1'b0;
	endtask

	// Draw one request. Half have a small m (k or n-k at most 12); the rest
	// are wide random or k > n.
	task automatic send_random_request();
		logic [ARG_W-1:0] n;
		logic [ARG_W-1:0] k;
		int               span;
		n = ARG_W'($urandom);
		span = (n < 12) ? n : 12;
		case ($urandom_range(3))
			0: k = ARG_W'($urandom);
			1: k = ARG_W'($urandom_range(span, 0));
			2: k = n - ARG_W'($urandom_range(span, 0));
			default: begin
				n = ARG_W'($urandom_range(254, 0));
				k = ARG_W'($urandom_range(255, n + 1));
			end
		endcase
		send_request(n, k);
	endtask

	task automatic test_corner_cases();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		send_request(8'd0, 8'd0);      // zero choice on an empty set
		send_request(8'd255, 8'd0);    // zero choice, widest n
		send_request(8'd255, 8'd255);  // m = 0 from the n-k side
		send_request(8'd0, 8'd255);    // k exceeds n, widest gap
		send_request(8'd10, 8'd11);    // k exceeds n by one
		send_request(8'd254, 8'd255);
		send_request(8'd1, 8'd1);
		send_request(8'd1, 8'd0);
		send_request(8'd255, 8'd1);
		send_request(8'd255, 8'd254);
		send_request(8'd255, 8'd8);    // numerator just fits
		send_request(8'd255, 8'd9);    // numerator just overflows
		send_request(8'd255, 8'd247);
		send_request(8'd255, 8'd248);
		send_request(8'd255, 8'd128);  // overflow, largest m
		send_request(8'd255, 8'd127);
		send_request(8'd22, 8'd11);
		send_request(8'd40, 8'd20);
		send_request(8'd20, 8'd10);
		send_request(8'd170, 8'd85);
		send_request(8'd85, 8'd170);
		send_request(8'd2, 8'd1);
		wait_drained();
	endtask

	// Stall the receiver long enough that the unit fills and drops req.ready.
	task automatic test_output_backpressure();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		fork
			hold_receiver(400);
		join_none
		repeat (10) send_random_request();
		wait_drained();
	endtask

	// Send a burst, stop until all answers are in, send again.
	task automatic test_sender_pause();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		repeat (6) send_random_request();
		wait_drained();
		repeat (6) send_random_request();
		wait_drained();
	endtask

	task automatic test_random_requests();
		int tx_mix[4] = '{0, 55, 0, 9};
		int rx_mix[4] = '{0, 0, 55, 9};
		for (int phase = 0; phase < 4; phase++) begin
			tx_idle_pct = tx_mix[phase];
			rx_stall_pct = rx_mix[phase];
			repeat (252) send_random_request();
		end
		idle_sender();
	endtask

	// Receiver: drive ready at random and check every accepted response
	// against the oldest open answer.
	always @(posedge clk) begin
		coeff_answer_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (open_answers.size() == 0) begin
				report_mismatch("unexpected response", rsp_if.coefficient, '0);
			end else begin
				want = open_answers.pop_front();
				if (rsp_if.coefficient !== want.coefficient)
					report_mismatch("coefficient", rsp_if.coefficient, want.coefficient);
				if (rsp_if.status !== want.status)
					report_mismatch("status", 64'(rsp_if.status), 64'(want.status));
			end
		end
		rsp_if.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
	end

	// Watchdog: end the run if it hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	initial begin
		arst_n       <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.n     <= '0;
		req_if.k     <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_cases();
		test_output_backpressure();
		test_sender_pause();
		test_random_requests();

		// Drain, then let any late response show up.
		while (open_answers.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule

// ----- binomial_coefficient_unit.f -----
+incdir+sv
sv/bcu_pkg.sv
sv/bcu_in_if.sv
sv/bcu_out_if.sv
sv/bcu_div.sv
sv/binomial_coefficient_unit.sv
dv/tb.sv
